FILE: design/sdet_pkg.sv
package sdet_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned KEY_W    = 2 * ADDR_W + CHAN_W;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2
  } status_e;

endpackage

FILE: design/sorted_dedup_entry_table.sv
// Sorted entry table with duplicate rejection, one command at a time.
// Insert: one pass up the table through a single comparator and one memory
//   read port, with one write per moved entry as the pass goes on.
// Read: one memory read through the same port.
// The result strobe follows the last cycle; the receiver cannot stall.
// Reset clears the count and the limit; table storage is not cleared.
module sorted_dedup_entry_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [sdet_pkg::OP_W-1:0]       operation_i,
  input  logic [sdet_pkg::ADDR_W-1:0]     src_addr_i,
  input  logic [sdet_pkg::ADDR_W-1:0]     dst_addr_i,
  input  logic [sdet_pkg::CHAN_W-1:0]     channel_i,
  input  logic [sdet_pkg::INDEX_W-1:0]    index_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sdet_pkg::LIMIT_W-1:0]    cfg_data_i,
  output logic                            done_o,
  output logic [sdet_pkg::STATUS_W-1:0]   status_o,
  output logic                            entry_valid_o,
  output logic [sdet_pkg::ADDR_W-1:0]     entry_src_o,
  output logic [sdet_pkg::ADDR_W-1:0]     entry_dst_o,
  output logic [sdet_pkg::CHAN_W-1:0]     entry_channel_o,
  output logic [sdet_pkg::COUNT_W-1:0]    entry_count_o,
  output logic                            table_full_o
);
  import sdet_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_RDOUT = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [LIMIT_W-1:0]  max_q;
  key_t                key_q, key_d;
  key_t                carry_q, carry_d;
  key_t                rdata_q;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                pend_q, pend_d;
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                valid_q, valid_d;
  key_t                entry_q, entry_d;

  key_t                mem_q [CAPACITY];
  logic                we;
  logic [AW-1:0]       waddr;
  key_t                wdata;
  logic [AW-1:0]       raddr;

  logic [AW-1:0]       cmp_ptr;
  logic                cmp_last;
  logic [LW-1:0]       limit;
  logic                full_now;
  key_t                key_in;

  assign key_in   = {src_addr_i, dst_addr_i, channel_i};
  assign cmp_ptr  = rd_ptr_q - AW'(1);
  assign cmp_last = (CW'(cmp_ptr) + CW'(1)) == count_q;
  assign limit    = (max_q == '0 || LW'(max_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_q);
  assign full_now = LW'(count_q) >= limit;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    key_d    = key_q;
    carry_d  = carry_q;
    rd_ptr_d = rd_ptr_q;
    pend_d   = pend_q;
    done_d   = 1'b0;
    status_d = status_q;
    valid_d  = valid_q;
    entry_d  = entry_q;
    we       = 1'b0;
    waddr    = cmp_ptr;
    wdata    = carry_q;
    raddr    = rd_ptr_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          key_d    = key_in;
          rd_ptr_d = '0;
          pend_d   = 1'b0;
          done_d   = 1'b1;
          status_d = ST_DONE;
          valid_d  = 1'b0;
          entry_d  = '0;
          unique case (op_e'(operation_i))
            OP_INSERT: begin
              if (full_now) begin
                status_d = ST_FULL;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = key_in;
                count_d = CW'(1);
              end else begin
                done_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            OP_READ: begin
              if (LW'(index_i) < LW'(count_q)) begin
                raddr   = AW'(index_i);
                done_d  = 1'b0;
                state_d = S_RDOUT;
              end
            end
            OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        rd_ptr_d = rd_ptr_q + AW'(1);
        pend_d   = 1'b1;
        if (pend_q) begin
          priority if (rdata_q == key_q) begin
            done_d   = 1'b1;
            status_d = ST_DUP;
            valid_d  = 1'b0;
            entry_d  = '0;
            state_d  = S_IDLE;
          end else if (rdata_q > key_q) begin
            we      = 1'b1;
            wdata   = key_q;
            carry_d = rdata_q;
            state_d = cmp_last ? S_TAIL : S_SHIFT;
          end else if (cmp_last) begin
            we       = 1'b1;
            waddr    = AW'(count_q);
            wdata    = key_q;
            count_d  = count_q + CW'(1);
            done_d   = 1'b1;
            status_d = ST_DONE;
            valid_d  = 1'b0;
            entry_d  = '0;
            state_d  = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        rd_ptr_d = rd_ptr_q + AW'(1);
        we       = 1'b1;
        carry_d  = rdata_q;
        if (cmp_last) state_d = S_TAIL;
      end
      S_TAIL: begin
        we       = 1'b1;
        waddr    = AW'(count_q);
        count_d  = count_q + CW'(1);
        done_d   = 1'b1;
        status_d = ST_DONE;
        valid_d  = 1'b0;
        entry_d  = '0;
        state_d  = S_IDLE;
      end
      S_RDOUT: begin
        done_d   = 1'b1;
        status_d = ST_DONE;
        valid_d  = 1'b1;
        entry_d  = rdata_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      max_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    carry_q  <= carry_d;
    rd_ptr_q <= rd_ptr_d;
    status_q <= status_d;
    valid_q  <= valid_d;
    entry_q  <= entry_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign entry_valid_o   = valid_q;
  assign entry_src_o     = entry_q[KEY_W-1 -: ADDR_W];
  assign entry_dst_o     = entry_q[CHAN_W +: ADDR_W];
  assign entry_channel_o = entry_q[CHAN_W-1:0];
  assign entry_count_o   = COUNT_W'(count_q);
  assign table_full_o    = full_now;

endmodule

FILE: design/sdet_chk.sv
module sdet_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [sdet_pkg::STATUS_W-1:0]   status_o,
  input logic                            entry_valid_o,
  input logic [sdet_pkg::ADDR_W-1:0]     entry_src_o,
  input logic [sdet_pkg::ADDR_W-1:0]     entry_dst_o,
  input logic [sdet_pkg::CHAN_W-1:0]     entry_channel_o
);
  import sdet_pkg::*;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither running nor finished");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !entry_valid_o) |->
      (entry_src_o == '0 && entry_dst_o == '0 && entry_channel_o == '0))
    else $error("entry fields nonzero without a valid read");

  a_reject_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> !entry_valid_o)
    else $error("rejected insert reports a valid entry");

endmodule

bind sorted_dedup_entry_table sdet_chk u_sdet_chk (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sdet_pkg::*;

  localparam int unsigned TABLE_DEPTH  = CAPACITY;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
  localparam logic [CHAN_W-1:0] CHAN_ONES = {CHAN_W{1'b1}};

  typedef struct packed {
    status_e            status;
    logic               valid;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [CHAN_W-1:0]  chan;
    logic [COUNT_W-1:0] count;
    logic               full;
  } entry_result_t;

  typedef struct {
    op_e                op;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [CHAN_W-1:0]  chan;
    logic [INDEX_W-1:0] index;
    bit                 pinned;
    entry_result_t      result;
  } command_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      operation_i;
  logic [ADDR_W-1:0]    src_addr_i;
  logic [ADDR_W-1:0]    dst_addr_i;
  logic [CHAN_W-1:0]    channel_i;
  logic [INDEX_W-1:0]   index_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [LIMIT_W-1:0]   cfg_data_i;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 entry_valid_o;
  logic [ADDR_W-1:0]    entry_src_o;
  logic [ADDR_W-1:0]    entry_dst_o;
  logic [CHAN_W-1:0]    entry_channel_o;
  logic [COUNT_W-1:0]   entry_count_o;
  logic                 table_full_o;

  // expectation typed into the directed table, travels with the command
  logic                 pin_valid;
  entry_result_t        pin_result;

  entry_result_t        results_due[$];
  logic [ADDR_W-1:0]    tbl_src [TABLE_DEPTH];
  logic [ADDR_W-1:0]    tbl_dst [TABLE_DEPTH];
  logic [CHAN_W-1:0]    tbl_chan [TABLE_DEPTH];
  int unsigned          tbl_count;
  logic [LIMIT_W-1:0]   tbl_limit;
  int unsigned          error_count;
  int unsigned          quiet_cycles;

  sorted_dedup_entry_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .src_addr_i      (src_addr_i),
    .dst_addr_i      (dst_addr_i),
    .channel_i       (channel_i),
    .index_i         (index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .entry_valid_o   (entry_valid_o),
    .entry_src_o     (entry_src_o),
    .entry_dst_o     (entry_dst_o),
    .entry_channel_o (entry_channel_o),
    .entry_count_o   (entry_count_o),
    .table_full_o    (table_full_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned active_limit();
    if (tbl_limit == '0 || int'(tbl_limit) > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(tbl_limit);
  endfunction

  function automatic entry_result_t apply_command(op_e op, logic [ADDR_W-1:0] s,
      logic [ADDR_W-1:0] d, logic [CHAN_W-1:0] c, logic [INDEX_W-1:0] idx);
    entry_result_t r;
    int unsigned pos;
    int unsigned k;
    logic [KEY_W-1:0] key;
    r = '0;
    key = {s, d, c};
    case (op)
      OP_INSERT: begin
        if (tbl_count >= active_limit()) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && {tbl_src[pos], tbl_dst[pos], tbl_chan[pos]} < key) pos++;
          if (pos < tbl_count && {tbl_src[pos], tbl_dst[pos], tbl_chan[pos]} == key) begin
            r.status = ST_DUP;
          end else begin
            for (k = tbl_count; k > pos; k--) begin
              tbl_src[k]  = tbl_src[k-1];
              tbl_dst[k]  = tbl_dst[k-1];
              tbl_chan[k] = tbl_chan[k-1];
            end
            tbl_src[pos]  = s;
            tbl_dst[pos]  = d;
            tbl_chan[pos] = c;
            tbl_count++;
          end
        end
      end
      OP_READ: begin
        if (int'(idx) < tbl_count) begin
          r.valid = 1'b1;
          r.src   = tbl_src[idx];
          r.dst   = tbl_dst[idx];
          r.chan  = tbl_chan[idx];
        end
      end
      OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.count = tbl_count[COUNT_W-1:0];
    r.full  = tbl_count >= active_limit();
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_W-1:0];
  endfunction

  function automatic command_row_t cmd(op_e op, logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] d,
      logic [CHAN_W-1:0] c, logic [INDEX_W-1:0] i);
    command_row_t row;
    row.op     = op;
    row.src    = s;
    row.dst    = d;
    row.chan   = c;
    row.index  = i;
    row.pinned = 1'b0;
    row.result = '0;
    return row;
  endfunction

  function automatic command_row_t cmd_pinned(op_e op, logic [ADDR_W-1:0] s,
      logic [ADDR_W-1:0] d, logic [CHAN_W-1:0] c, logic [INDEX_W-1:0] i, entry_result_t r);
    command_row_t row;
    row = cmd(op, s, d, c, i);
    row.pinned = 1'b1;
    row.result = r;
    return row;
  endfunction

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    entry_result_t want;
    entry_result_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (results_due.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected: status %0d count %0d", $time,
                   status_o, entry_count_o);
        end else begin
          want = results_due.pop_front();
          check_field("status", ADDR_W'(want.status), ADDR_W'(status_o));
          check_field("entry_valid", ADDR_W'(want.valid), ADDR_W'(entry_valid_o));
          check_field("entry_src", want.src, entry_src_o);
          check_field("entry_dst", want.dst, entry_dst_o);
          check_field("entry_channel", ADDR_W'(want.chan), ADDR_W'(entry_channel_o));
          check_field("entry_count", ADDR_W'(want.count), ADDR_W'(entry_count_o));
          check_field("table_full", ADDR_W'(want.full), ADDR_W'(table_full_o));
        end
      end
      if (start && !busy) begin
        predicted = apply_command(op_e'(operation_i), src_addr_i, dst_addr_i, channel_i,
                                  index_i);
        results_due.push_back(pin_valid ? pin_result : predicted);
      end
      if (cfg_valid_i && cfg_ready_o) tbl_limit = cfg_data_i;
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // ends at a falling edge where nothing has been driven yet
  task automatic idle_gap(int unsigned pct);
    int unsigned n;
    n = 0;
    while (n < 40 && $urandom_range(99) < pct) n++;
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
  endtask

  task automatic drive_command(command_row_t row);
    start       <= 1'b1;
    operation_i <= row.op;
    src_addr_i  <= row.src;
    dst_addr_i  <= row.dst;
    channel_i   <= row.chan;
    index_i     <= row.index;
    pin_valid   <= row.pinned;
    pin_result  <= row.result;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // when the table holds entries, half the keys are equal or close to stored ones, so ordering and duplicates get hit
  task automatic pick_key(inout command_row_t row);
    int unsigned mode;
    int unsigned pos;
    logic [31:0] r;
    mode = $urandom_range(99);
    r = $urandom;
    if (tbl_count != 0 && mode < 50) begin
      pos = $urandom_range(tbl_count - 1);
      row.src  = tbl_src[pos];
      row.dst  = tbl_dst[pos];
      row.chan = tbl_chan[pos];
      if (mode >= 25) begin
        case (r[1:0])
          2'd0: row.chan = r[15:8];
          2'd1: row.dst = r[2] ? row.dst + ADDR_W'(1) : row.dst - ADDR_W'(1);
          2'd2: row.src = r[2] ? row.src + ADDR_W'(1) : row.src - ADDR_W'(1);
          default: row.dst = rand48();
        endcase
      end
    end else if (mode < 62) begin
      row.src  = r[1:0] == 2'd0 ? '0 : r[1:0] == 2'd1 ? ADDR_ONES : row.src;
      row.dst  = r[3:2] == 2'd0 ? '0 : r[3:2] == 2'd1 ? ADDR_ONES : row.dst;
      row.chan = r[5:4] == 2'd0 ? '0 : r[5:4] == 2'd1 ? CHAN_ONES : row.chan;
    end
  endtask

  task automatic random_command(int unsigned pct, bit clears);
    command_row_t row;
    int unsigned pick;
    int unsigned pos;
    logic [31:0] r;
    idle_gap(pct);
    r = $urandom;
    row = cmd(OP_NONE, rand48(), rand48(), r[7:0], r[13:8]);
    pick = $urandom_range(99);
    if (pick < 55) begin
      row.op = OP_INSERT;
      pick_key(row);
    end else if (pick < 88) begin
      row.op = OP_READ;
      if (r[17:16] != 2'd0 && tbl_count != 0) begin
        pos = $urandom_range(tbl_count - 1);
        row.index = pos[INDEX_W-1:0];
      end
    end else if (pick >= 94 && clears) begin
      row.op = OP_CLEAR;
    end
    drive_command(row);
  endtask

  initial begin
    command_row_t directed[$];
    command_row_t row;
    logic [31:0] r;
    int unsigned k;
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = '0;
    src_addr_i   = '0;
    dst_addr_i   = '0;
    channel_i    = '0;
    index_i      = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    pin_valid    = 1'b0;
    pin_result   = '0;
    tbl_count    = 0;
    tbl_limit    = '0;
    error_count  = 0;
    quiet_cycles = 0;

    directed.push_back(cmd_pinned(OP_READ, '0, '0, '0, 6'd0,
        entry_result_t'{ST_DONE, 1'b0, 48'h0, 48'h0, 8'h0, 7'd0, 1'b0}));
    directed.push_back(cmd_pinned(OP_NONE, ADDR_ONES, ADDR_ONES, CHAN_ONES, 6'd63,
        entry_result_t'{ST_DONE, 1'b0, 48'h0, 48'h0, 8'h0, 7'd0, 1'b0}));
    directed.push_back(cmd_pinned(OP_INSERT, ADDR_ONES, ADDR_ONES, CHAN_ONES, 6'd0,
        entry_result_t'{ST_DONE, 1'b0, 48'h0, 48'h0, 8'h0, 7'd1, 1'b0}));
    directed.push_back(cmd_pinned(OP_INSERT, '0, '0, '0, 6'd0,
        entry_result_t'{ST_DONE, 1'b0, 48'h0, 48'h0, 8'h0, 7'd2, 1'b0}));
    directed.push_back(cmd_pinned(OP_INSERT, ADDR_ONES, ADDR_ONES, CHAN_ONES, 6'd0,
        entry_result_t'{ST_DUP, 1'b0, 48'h0, 48'h0, 8'h0, 7'd2, 1'b0}));
    directed.push_back(cmd_pinned(OP_READ, '0, '0, '0, 6'd0,
        entry_result_t'{ST_DONE, 1'b1, 48'h0, 48'h0, 8'h0, 7'd2, 1'b0}));
    directed.push_back(cmd_pinned(OP_READ, '0, '0, '0, 6'd1,
        entry_result_t'{ST_DONE, 1'b1, ADDR_ONES, ADDR_ONES, CHAN_ONES, 7'd2, 1'b0}));
    directed.push_back(cmd_pinned(OP_READ, '0, '0, '0, 6'd63,
        entry_result_t'{ST_DONE, 1'b0, 48'h0, 48'h0, 8'h0, 7'd2, 1'b0}));
    // keys that an or-of-fields compare would misplace
    directed.push_back(cmd(OP_INSERT, ADDR_ONES, '0, '0, 6'd0));
    directed.push_back(cmd(OP_INSERT, '0, ADDR_ONES, '0, 6'd0));
    directed.push_back(cmd(OP_INSERT, '0, '0, CHAN_ONES, 6'd0));
    directed.push_back(cmd(OP_INSERT, '0, '0, 8'h01, 6'd0));
    directed.push_back(cmd(OP_INSERT, 48'h1, '0, '0, 6'd0));
    directed.push_back(cmd(OP_INSERT, 48'h8000_0000_0000, 48'h7fff_ffff_ffff, 8'h80, 6'd0));
    directed.push_back(cmd(OP_INSERT, '0, ADDR_ONES, '0, 6'd0));
    for (k = 0; k < 9; k++) directed.push_back(cmd(OP_READ, '0, '0, '0, k[INDEX_W-1:0]));
    directed.push_back(cmd_pinned(OP_CLEAR, '0, '0, '0, 6'd0,
        entry_result_t'{ST_DONE, 1'b0, 48'h0, 48'h0, 8'h0, 7'd0, 1'b0}));
    directed.push_back(cmd_pinned(OP_READ, '0, '0, '0, 6'd0,
        entry_result_t'{ST_DONE, 1'b0, 48'h0, 48'h0, 8'h0, 7'd0, 1'b0}));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < directed.size(); k++) begin
      idle_gap(0);
      drive_command(directed[k]);
    end

    // fill to capacity, then push past it
    write_limit('0);
    for (k = 0; k < TABLE_DEPTH + 3; k++) begin
      idle_gap(0);
      r = $urandom;
      drive_command(cmd(OP_INSERT, rand48(), rand48(), r[7:0], r[13:8]));
    end
    drain();
    // stored keys while full: full wins over duplicate
    for (k = 0; k < 4; k++) begin
      idle_gap(0);
      r = $urandom_range(TABLE_DEPTH - 1);
      row = cmd(OP_INSERT, tbl_src[r[5:0]], tbl_dst[r[5:0]], tbl_chan[r[5:0]], 6'd0);
      drive_command(row);
    end

    // limit below the held count
    write_limit(7'd5);
    repeat (20) random_command(69, 1'b0);
    write_limit(7'd127);
    repeat (90) random_command(35, 1'b1);
    write_limit(7'd1);
    repeat (60) random_command(69, 1'b1);
    write_limit(7'd64);
    repeat (90) random_command(0, 1'b1);
    r = $urandom_range(63, 2);
    write_limit(r[LIMIT_W-1:0]);
    repeat (50) random_command(69, 1'b1);
    repeat (50) random_command(0, 1'b1);
    write_limit(7'd3);
    repeat (60) random_command(35, 1'b1);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: sorted_dedup_entry_table.f
design/sdet_pkg.sv
design/sorted_dedup_entry_table.sv
design/sdet_chk.sv
bench/testbench.sv
